// ===== hw/rtl/wav_header_parser_unit_macros.svh =====
// ----------------------------------------------------------------------------
// wav header parser assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef WAV_HEADER_PARSER_UNIT_MACROS_SVH
`define WAV_HEADER_PARSER_UNIT_MACROS_SVH

`ifndef SYNTH
// check sampled on clk, off while rst is high
`define WHP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wav header parser: check failed");
// check sampled on clk, also active during reset
`define WHP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wav header parser: check failed");
`else
`define WHP_ASSERT(lbl, prop)
`define WHP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hw/rtl/wavhp_pkg.sv =====
// ----------------------------------------------------------------------------
// wav header parser package
// shared constants, state encodings and controller/datapath structs
// ----------------------------------------------------------------------------
package wavhp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_MIN_BYTES = 32'd16;
  localparam logic [15:0] LIMIT_RESET   = 16'd200;
  localparam logic [16:0] OFFSET_MAX    = 17'h1_FFFF;

  // bytes per frame: 16-bit channels times 13-bit whole bytes per sample
  localparam int unsigned BPF_W = 29;

  // register select bit of paddr (byte address / 4)
  localparam logic REG_SEARCH_LIMIT = 1'b0;

  typedef enum logic [2:0] {
    PH_RIFF,
    PH_RSIZE,
    PH_WAVE,
    PH_HDR,
    PH_FMT,
    PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    JOB_RUN,
    JOB_IGNORE,
    JOB_MUL,
    JOB_DSTART,
    JOB_DWAIT,
    JOB_LOAD
  } job_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_RIFF,
    ST_BAD_WAVE,
    ST_MISSING
  } status_t;

  typedef struct packed {
    logic    take;
    logic    clear;
    phase_t  phase;
    logic    idx_clr;
    logic    hdr_clr;
    logic    skip_load;
    logic    fmt_done;
    logic    mul_go;
    logic    div_start;
    logic    out_load;
    status_t out_code;
  } cmd_t;

  typedef struct packed {
    logic idx_eq3;
    logic idx_ge3;
    logic idx_ge7;
    logic idx_ge15;
    logic riff_ok;
    logic wave_ok;
    logic fmt_tag;
    logic data_tag;
    logic len_ge16;
    logic limit_hit;
    logic skip_zero;
    logic skip_one;
    logic fmt_seen;
    logic div_busy;
  } sts_t;

endpackage

// ===== hw/rtl/wavhp_div.sv =====
// ----------------------------------------------------------------------------
// wavhp divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wavhp_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [31:0]                    dividend,
  input  logic [wavhp_pkg::BPF_W-1:0]    divisor,
  output logic                           busy,
  output logic [31:0]                    quotient
);

  logic [wavhp_pkg::BPF_W-1:0] rem;
  logic [wavhp_pkg::BPF_W:0]   rem_sh;
  logic                        ge;
  logic [4:0]                  count;

  assign rem_sh = {rem, quotient[31]};
  assign ge     = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 5'd1;
      if (count == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      if (ge) begin
        rem <= wavhp_pkg::BPF_W'(rem_sh - {1'b0, divisor});
      end else begin
        rem <= wavhp_pkg::BPF_W'(rem_sh);
      end
      quotient <= {quotient[30:0], ge};
    end
  end

endmodule

// ===== hw/rtl/wavhp_dp.sv =====
// ----------------------------------------------------------------------------
// wavhp datapath
// byte assembly, chunk bookkeeping, fmt capture, frame count and result regs
// ----------------------------------------------------------------------------
module wavhp_dp (
  input  logic                clk,
  input  logic                rst,
  input  wavhp_pkg::cmd_t     cmd,
  input  logic [7:0]          data_byte,
  input  logic [15:0]         search_limit,
  output wavhp_pkg::sts_t     sts,
  output wavhp_pkg::status_t  status,
  output logic [15:0]         channel_count,
  output logic [31:0]         rate_hz,
  output logic [15:0]         sample_bits,
  output logic [31:0]         payload_bytes,
  output logic [16:0]         payload_offset,
  output logic [31:0]         frame_total
);

  logic [4:0]  idx;
  logic [31:0] tag;
  logic [31:0] len;
  logic [16:0] off;
  logic [32:0] skip;
  logic [15:0] held_ch;
  logic [31:0] held_rate;
  logic [15:0] held_bits;
  logic        fmt_seen;
  logic [wavhp_pkg::BPF_W-1:0] bpf;

  logic [4:0]  eff_idx;
  logic [31:0] eff_tag;
  logic [31:0] eff_len;
  logic [16:0] eff_off;
  logic [16:0] off_next;
  logic [31:0] lane;
  logic [31:0] tag_next;
  logic [31:0] len_next;
  logic [32:0] skip_amt;
  logic [33:0] hdr_pos;
  logic        div_busy;
  logic [31:0] quot;

  // first byte of a file starts from a clean parse
  assign eff_idx = cmd.clear ? '0 : idx;
  assign eff_tag = cmd.clear ? '0 : tag;
  assign eff_len = cmd.clear ? '0 : len;
  assign eff_off = cmd.clear ? '0 : off;

  assign off_next = (eff_off >= wavhp_pkg::OFFSET_MAX) ? wavhp_pkg::OFFSET_MAX
                                                       : eff_off + 17'd1;
  assign lane = {24'b0, data_byte} << {eff_idx[1:0], 3'b000};

  always_comb begin
    tag_next = eff_tag;
    len_next = eff_len;
    skip_amt = '0;
    case (cmd.phase)
      wavhp_pkg::PH_RIFF, wavhp_pkg::PH_WAVE: begin
        tag_next = eff_tag | lane;
      end
      wavhp_pkg::PH_HDR: begin
        if (eff_idx < 5'd4) begin
          tag_next = eff_tag | lane;
        end else begin
          len_next = eff_len | lane;
        end
        // whole body plus pad byte on odd size
        skip_amt = {1'b0, len_next} + 33'(len_next[0]);
      end
      wavhp_pkg::PH_FMT: begin
        // rest of the fmt body plus pad
        skip_amt = {1'b0, eff_len - wavhp_pkg::FMT_MIN_BYTES} + 33'(eff_len[0]);
      end
      default: begin
      end
    endcase
  end

  // offset of the next chunk header
  assign hdr_pos = {17'b0, off_next} + {1'b0, skip_amt};

  always_comb begin
    sts.idx_eq3   = eff_idx == 5'd3;
    sts.idx_ge3   = eff_idx >= 5'd3;
    sts.idx_ge7   = eff_idx >= 5'd7;
    sts.idx_ge15  = eff_idx >= 5'd15;
    sts.riff_ok   = tag_next == wavhp_pkg::TAG_RIFF;
    sts.wave_ok   = tag_next == wavhp_pkg::TAG_WAVE;
    sts.fmt_tag   = tag_next == wavhp_pkg::TAG_FMT;
    sts.data_tag  = tag_next == wavhp_pkg::TAG_DATA;
    sts.len_ge16  = len_next >= wavhp_pkg::FMT_MIN_BYTES;
    sts.limit_hit = hdr_pos >= {18'b0, search_limit};
    sts.skip_zero = skip_amt == '0;
    sts.skip_one  = skip == 33'd1;
    sts.fmt_seen  = fmt_seen;
    sts.div_busy  = div_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      tag       <= '0;
      len       <= '0;
      off       <= '0;
      skip      <= '0;
      held_ch   <= '0;
      held_rate <= '0;
      held_bits <= '0;
      fmt_seen  <= 1'b0;
    end else if (cmd.take) begin
      idx <= cmd.idx_clr ? '0 : eff_idx + 5'd1;
      tag <= cmd.hdr_clr ? '0 : tag_next;
      len <= cmd.hdr_clr ? '0 : len_next;
      off <= off_next;
      if (cmd.skip_load) begin
        skip <= skip_amt;
      end else if (cmd.phase == wavhp_pkg::PH_SKIP) begin
        skip <= skip - 33'd1;
      end
      if (cmd.clear) begin
        held_ch   <= '0;
        held_rate <= '0;
        held_bits <= '0;
        fmt_seen  <= 1'b0;
      end else if (cmd.phase == wavhp_pkg::PH_FMT) begin
        case (eff_idx)
          5'd2:    held_ch[7:0]     <= data_byte;
          5'd3:    held_ch[15:8]    <= data_byte;
          5'd4:    held_rate[7:0]   <= data_byte;
          5'd5:    held_rate[15:8]  <= data_byte;
          5'd6:    held_rate[23:16] <= data_byte;
          5'd7:    held_rate[31:24] <= data_byte;
          5'd14:   held_bits[7:0]   <= data_byte;
          5'd15:   held_bits[15:8]  <= data_byte;
          default: begin
          end
        endcase
        if (cmd.fmt_done) begin
          fmt_seen <= 1'b1;
        end
      end
    end
  end

  // bytes per frame, one registered multiply
  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      bpf <= held_ch * held_bits[15:3];
    end
  end

  wavhp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (len),
    .divisor  (bpf),
    .busy     (div_busy),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= cmd.out_code;
      if (cmd.out_code == wavhp_pkg::ST_OK) begin
        channel_count  <= held_ch;
        rate_hz        <= held_rate;
        sample_bits    <= held_bits;
        payload_bytes  <= len;
        payload_offset <= off;
        frame_total    <= (bpf == '0) ? '0 : quot;
      end else begin
        channel_count  <= '0;
        rate_hz        <= '0;
        sample_bits    <= '0;
        payload_bytes  <= '0;
        payload_offset <= '0;
        frame_total    <= '0;
      end
    end
  end

endmodule

// ===== hw/rtl/wavhp_ctrl.sv =====
// ----------------------------------------------------------------------------
// wavhp controller
// parse phase and job sequencing, result handshake
// ----------------------------------------------------------------------------
module wavhp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_first,
  input  logic             in_last,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  wavhp_pkg::sts_t  sts,
  output wavhp_pkg::cmd_t  cmd
);

  wavhp_pkg::phase_t  phase, phase_next, ph;
  wavhp_pkg::job_t    job, job_next;
  wavhp_pkg::status_t res_code;
  logic               res_v;
  logic               out_free;
  logic               in_take;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= wavhp_pkg::PH_RIFF;
      job       <= wavhp_pkg::JOB_RUN;
      out_valid <= 1'b0;
    end else begin
      job <= job_next;
      if (cmd.take) begin
        phase <= phase_next;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd        = '0;
    job_next   = job;
    phase_next = wavhp_pkg::PH_RIFF;
    res_v      = 1'b0;
    res_code   = wavhp_pkg::ST_OK;
    in_ready   = 1'b0;
    in_take    = 1'b0;
    ph         = in_first ? wavhp_pkg::PH_RIFF : phase;

    case (job)
      wavhp_pkg::JOB_RUN, wavhp_pkg::JOB_IGNORE: begin
        in_ready = out_free;
        in_take  = in_valid && out_free;
      end
      default: begin
      end
    endcase

    // after a result, bytes are dropped until a new file starts
    cmd.take  = in_take && (job == wavhp_pkg::JOB_RUN || in_first);
    cmd.clear = cmd.take && in_first;
    cmd.phase = ph;
    phase_next = ph;

    case (ph)
      wavhp_pkg::PH_RIFF: begin
        if (sts.idx_eq3) begin
          if (!sts.riff_ok) begin
            res_v    = 1'b1;
            res_code = wavhp_pkg::ST_BAD_RIFF;
          end else begin
            phase_next  = wavhp_pkg::PH_RSIZE;
            cmd.idx_clr = 1'b1;
          end
        end
      end
      wavhp_pkg::PH_RSIZE: begin
        if (sts.idx_ge3) begin
          phase_next  = wavhp_pkg::PH_WAVE;
          cmd.idx_clr = 1'b1;
          cmd.hdr_clr = 1'b1;
        end
      end
      wavhp_pkg::PH_WAVE: begin
        if (sts.idx_eq3) begin
          if (!sts.wave_ok) begin
            res_v    = 1'b1;
            res_code = wavhp_pkg::ST_BAD_WAVE;
          end else if (sts.limit_hit) begin
            res_v    = 1'b1;
            res_code = wavhp_pkg::ST_MISSING;
          end else begin
            phase_next  = wavhp_pkg::PH_HDR;
            cmd.idx_clr = 1'b1;
            cmd.hdr_clr = 1'b1;
          end
        end
      end
      wavhp_pkg::PH_HDR: begin
        if (sts.idx_ge7) begin
          if (sts.data_tag) begin
            res_v    = 1'b1;
            res_code = sts.fmt_seen ? wavhp_pkg::ST_OK : wavhp_pkg::ST_MISSING;
          end else if (sts.fmt_tag && sts.len_ge16) begin
            phase_next  = wavhp_pkg::PH_FMT;
            cmd.idx_clr = 1'b1;
          end else if (sts.limit_hit) begin
            res_v    = 1'b1;
            res_code = wavhp_pkg::ST_MISSING;
          end else if (sts.skip_zero) begin
            phase_next  = wavhp_pkg::PH_HDR;
            cmd.idx_clr = 1'b1;
            cmd.hdr_clr = 1'b1;
          end else begin
            phase_next    = wavhp_pkg::PH_SKIP;
            cmd.skip_load = 1'b1;
          end
        end
      end
      wavhp_pkg::PH_FMT: begin
        if (sts.idx_ge15) begin
          cmd.fmt_done = 1'b1;
          if (sts.limit_hit) begin
            res_v    = 1'b1;
            res_code = wavhp_pkg::ST_MISSING;
          end else if (sts.skip_zero) begin
            phase_next  = wavhp_pkg::PH_HDR;
            cmd.idx_clr = 1'b1;
            cmd.hdr_clr = 1'b1;
          end else begin
            phase_next    = wavhp_pkg::PH_SKIP;
            cmd.skip_load = 1'b1;
          end
        end
      end
      wavhp_pkg::PH_SKIP: begin
        if (sts.skip_one) begin
          phase_next  = wavhp_pkg::PH_HDR;
          cmd.idx_clr = 1'b1;
          cmd.hdr_clr = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // end of file before a decision
    if (!res_v && in_last) begin
      res_v = 1'b1;
      case (phase_next)
        wavhp_pkg::PH_RIFF, wavhp_pkg::PH_RSIZE: res_code = wavhp_pkg::ST_BAD_RIFF;
        wavhp_pkg::PH_WAVE:                      res_code = wavhp_pkg::ST_BAD_WAVE;
        default:                                 res_code = wavhp_pkg::ST_MISSING;
      endcase
    end

    case (job)
      wavhp_pkg::JOB_RUN, wavhp_pkg::JOB_IGNORE: begin
        if (cmd.take && res_v) begin
          if (res_code == wavhp_pkg::ST_OK) begin
            job_next = wavhp_pkg::JOB_MUL;
          end else begin
            cmd.out_load = 1'b1;
            cmd.out_code = res_code;
            job_next     = wavhp_pkg::JOB_IGNORE;
          end
        end else if (cmd.take) begin
          job_next = wavhp_pkg::JOB_RUN;
        end
      end
      wavhp_pkg::JOB_MUL: begin
        cmd.mul_go = 1'b1;
        job_next   = wavhp_pkg::JOB_DSTART;
      end
      wavhp_pkg::JOB_DSTART: begin
        cmd.div_start = 1'b1;
        job_next      = wavhp_pkg::JOB_DWAIT;
      end
      wavhp_pkg::JOB_DWAIT: begin
        if (!sts.div_busy) begin
          job_next = wavhp_pkg::JOB_LOAD;
        end
      end
      wavhp_pkg::JOB_LOAD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_code = wavhp_pkg::ST_OK;
          job_next     = wavhp_pkg::JOB_IGNORE;
        end
      end
      default: begin
        job_next = wavhp_pkg::JOB_RUN;
      end
    endcase
  end

endmodule

// ===== hw/rtl/wav_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// wav header parser unit
// streams a RIFF/WAVE file one byte per item and reports its format summary
// ----------------------------------------------------------------------------
// The file enters one byte per input item; first_byte (tuser) starts a new
// file and last_byte (tlast) marks its end. The block checks the RIFF magic
// and WAVE tag, walks chunk headers, captures channels, sample rate and bit
// depth from a fmt chunk of at least 16 bytes and stops at the first data
// chunk header. Each file yields exactly one result item: status 0 with the
// fmt values, data size, data offset and frame count, or an error status
// (1 bad RIFF, 2 bad WAVE, 3 fmt/data missing, end of file after the WAVE tag
// or a chunk header at or past search_limit) with all other fields zero.
// Bytes after a result are accepted and dropped until the next first_byte.
// While parsing, one byte is taken every cycle. An error result is ready on
// the cycle after the byte that decides it. A good result passes through a
// multiply for bytes per frame, a divider start, the bit-serial divider run,
// a step that sees the divider idle and a load step after the data chunk
// header byte is taken; input is held off during that time. The input also
// stalls while a finished result waits and the output side is not ready.
// search_limit sits at APB byte address 0, reset value 200.
// ----------------------------------------------------------------------------
`include "wav_header_parser_unit_macros.svh"

module wav_header_parser_unit (
  input  logic         clk,
  input  logic         rst,

  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic [0:0]   s_tuser,   // [0] first_byte
  input  logic         s_tlast,   // last_byte

  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // [1:0] status, [17:2] channel_count, [49:18] rate_hz, [65:50] sample_bits,
  // [97:66] payload_bytes, [114:98] payload_offset, [146:115] frame_total,
  // [151:147] zero
  output logic [151:0] m_tdata,

  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [15:0]         search_limit;
  wavhp_pkg::cmd_t     cmd;
  wavhp_pkg::sts_t     sts;
  wavhp_pkg::status_t  status;
  logic [15:0]         channel_count;
  logic [31:0]         rate_hz;
  logic [15:0]         sample_bits;
  logic [31:0]         payload_bytes;
  logic [16:0]         payload_offset;
  logic [31:0]         frame_total;

  // apb register file: a single word, always ready
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_limit <= wavhp_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == wavhp_pkg::REG_SEARCH_LIMIT) begin
      search_limit <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == wavhp_pkg::REG_SEARCH_LIMIT) begin
      prdata = {16'b0, search_limit};
    end else begin
      prdata = '0;
    end
  end

  // sequencing: parse phase, multiply/divide steps and result handshake
  wavhp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_first  (s_tuser[0]),
    .in_last   (s_tlast),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // byte fields, chunk counters, fmt values, divider and result registers
  wavhp_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .data_byte      (s_tdata),
    .search_limit   (search_limit),
    .sts            (sts),
    .status         (status),
    .channel_count  (channel_count),
    .rate_hz        (rate_hz),
    .sample_bits    (sample_bits),
    .payload_bytes  (payload_bytes),
    .payload_offset (payload_offset),
    .frame_total    (frame_total)
  );

  assign m_tdata = {5'b0, frame_total, payload_offset, payload_bytes,
                    sample_bits, rate_hz, channel_count, status};

  // a waiting result must hold the input side off
  `WHP_ASSERT(a_stall_blocks_input, (m_tvalid && !m_tready) |-> !s_tready)
  // the result register is only written when it is free
  `WHP_ASSERT(a_load_when_free, cmd.out_load |-> (!m_tvalid || m_tready))
  // no division is started on top of a running one
  `WHP_ASSERT(a_div_start_idle, cmd.div_start |-> !sts.div_busy)
  // reset leaves no result pending
  `WHP_ASSERT_ALWAYS(a_reset_clears_out, $past(rst) |-> !m_tvalid)

endmodule
